FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the cache directory RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define SALC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("salc same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define SALC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("salc next-cycle check failed");

`endif

FILE: hw/rtl/salc_pkg.sv
`timescale 1ns / 1ps
// Package for the set-associative LRU cache directory: geometry constants,
// channel payload types, the decoded item type and the set row layout. No dependencies.
package salc_pkg;

   localparam int SETS        = 256;
   localparam int WAYS        = 4;
   localparam int OFFSET_BITS = 5;
   localparam int ADDR_BITS   = 32;

   localparam int ADDR_FIELD_BITS = 32;
   localparam int EFF_ADDR_BITS   = (ADDR_BITS < ADDR_FIELD_BITS) ? ADDR_BITS : ADDR_FIELD_BITS;
   localparam int SET_BITS        = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS        = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_BITS        = EFF_ADDR_BITS - OFFSET_BITS - SET_BITS;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way_used;
      logic        forward_miss;
      logic [31:0] access_total;
      logic [31:0] load_total;
      logic [31:0] store_total;
      logic [31:0] hit_total;
      logic [31:0] load_hit_total;
      logic [31:0] store_hit_total;
   } rsp_type;

   // One classified access as it travels from the front to the back.
   typedef struct packed {
      logic                is_load;
      logic                is_store;
      logic [SET_BITS-1:0] set;
      logic [TAG_BITS-1:0] tag;
   } item_type;

   // Status of the queue as seen by its producer and consumer.
   typedef struct packed {
      logic avail;
      logic full;
   } queue_flags_type;

   typedef logic [WAYS-1:0][WAY_BITS-1:0] order_type;

   // One set: recency list (most recent first), way valid bits and way tags.
   typedef struct packed {
      order_type                     order;
      logic [WAYS-1:0]               valid;
      logic [WAYS-1:0][TAG_BITS-1:0] tags;
   } row_type;

   function automatic order_type reset_order();
      order_type r;
      for (int k = 0; k < WAYS; k++) begin
         r[k] = WAY_BITS'(k);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/set_assoc_lru_cache_lookup_unit.sv
`timescale 1ns / 1ps
// Top level of the four-way set-associative LRU cache directory.
// Depends on salc_pkg, salc_front, salc_queue and salc_back.
//
//   Channel   Ports                              Carries
//   --------  ---------------------------------  -----------------------------------------
//   request   req_valid, req_stall, req_data     one access item: kind and byte address
//   response  rsp_valid, rsp_stall, rsp_data     one result item: hit, way, miss, counters
//
// An item is held in the front register, then waits in a two-entry queue.
// The back end takes one item at a time: a registered read of the set row memory in
// ST_FETCH, then ST_RESOLVE matches tags, updates recency and writes the row back.
// Reset clears the per-set row-valid flops at once, so no clearing pass is needed and
// the block accepts items as soon as reset is released.
// A stalled response holds in the output register while the front and queue keep
// accepting; the request side stalls only once the queue and the front register fill.
module set_assoc_lru_cache_lookup_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  salc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output salc_pkg::rsp_type rsp_data
);
   import salc_pkg::*;

   // Classified items move from the front into the queue, and the back pops them
   // one at a time once its previous item has been written back.
   logic            push;
   item_type        push_item;
   logic            pop;
   item_type        head_item;
   queue_flags_type q_flags;

   salc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_item (push_item),
      .q_flags   (q_flags)
   );

   salc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_flags   (q_flags)
   );

   // The back holds the set rows, the event counters and the response register.
   salc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_flags   (q_flags),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/salc_front.sv
`timescale 1ns / 1ps
// Front end of the cache directory: accepts accesses and splits them into set and tag.
// Depends on salc_pkg.
module salc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  salc_pkg::req_type         req_data,
   output logic                      push,
   output salc_pkg::item_type        push_item,
   input  salc_pkg::queue_flags_type q_flags
);
   import salc_pkg::*;

   logic     held_valid_ff, held_valid_in;
   item_type held_item_ff, held_item_in;
   logic     accept;

   assign req_stall = held_valid_ff && q_flags.full;
   assign accept    = req_valid && !req_stall;
   assign push      = held_valid_ff && !q_flags.full;
   assign push_item = held_item_ff;

   always_comb begin
      held_item_in.is_load  = (req_data.kind == KIND_LOAD);
      held_item_in.is_store = (req_data.kind == KIND_STORE);
      held_item_in.set      = req_data.address[OFFSET_BITS +: SET_BITS];
      held_item_in.tag      = req_data.address[OFFSET_BITS + SET_BITS +: TAG_BITS];
   end

   always_comb begin
      held_valid_in = held_valid_ff;
      if (accept) begin
         held_valid_in = 1'b1;
      end else if (push) begin
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_item_ff <= held_item_in;
      end
   end

endmodule

FILE: hw/rtl/salc_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and the back of the directory.
// Depends on salc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module salc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  salc_pkg::item_type        push_item,
   input  logic                      pop,
   output salc_pkg::item_type        head_item,
   output salc_pkg::queue_flags_type q_flags
);
   import salc_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign head_item     = entry_ff[rd_ptr_ff];
   assign q_flags.avail = (count_ff != '0);
   assign q_flags.full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `SALC_ASSERT_NOW(a_queue_no_underflow, pop, count_ff != '0)
   `SALC_ASSERT_NOW(a_queue_no_overflow, push, (count_ff != COUNT_BITS'(QUEUE_DEPTH)) || pop)

endmodule

FILE: hw/rtl/salc_back.sv
`timescale 1ns / 1ps
// Back end of the cache directory: set row memory, tag match, LRU update and counters.
// Depends on salc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module salc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  salc_pkg::item_type        head_item,
   input  salc_pkg::queue_flags_type q_flags,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output salc_pkg::rsp_type         rsp_data
);
   import salc_pkg::*;

   typedef enum logic [1:0] {
      ST_FETCH   = 2'b01,
      ST_RESOLVE = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   row_type         row_mem_ff [SETS];
   row_type         rd_row_ff;
   logic            rd_known_ff;
   logic [SETS-1:0] row_valid_ff;
   item_type        item_ff;

   logic [31:0] access_ff, access_in;
   logic [31:0] load_ff, load_in;
   logic [31:0] store_ff, store_in;
   logic [31:0] hits_ff, hits_in;
   logic [31:0] load_hits_ff, load_hits_in;
   logic [31:0] store_hits_ff, store_hits_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   row_type             row_cur;
   row_type             row_in;
   logic                hit;
   logic                found;
   logic                pos_found;
   logic [WAY_BITS-1:0] way;
   logic [WAY_BITS-1:0] pos;
   logic                do_write;

   assign pop       = (state_ff == ST_FETCH) && q_flags.avail;
   assign do_write  = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A row that was never written reads as its reset contents.
   always_comb begin
      row_cur = rd_row_ff;
      if (!rd_known_ff) begin
         row_cur.order = reset_order();
         row_cur.valid = '0;
      end
   end

   always_comb begin
      hit       = 1'b0;
      found     = 1'b0;
      pos_found = 1'b0;
      way       = '0;
      pos       = '0;
      row_in    = row_cur;

      for (int k = 0; k < WAYS; k++) begin
         if (!hit && row_cur.valid[k] && (row_cur.tags[k] == item_ff.tag)) begin
            hit = 1'b1;
            way = WAY_BITS'(k);
         end
      end

      // On a miss, take the first invalid way in recency order, else the oldest way.
      if (!hit) begin
         for (int k = 0; k < WAYS; k++) begin
            if (!found && !row_cur.valid[row_cur.order[k]]) begin
               found = 1'b1;
               way   = row_cur.order[k];
            end
         end
         if (!found) begin
            way = row_cur.order[WAYS-1];
         end
         row_in.valid[way] = 1'b1;
         row_in.tags[way]  = item_ff.tag;
      end

      for (int k = 0; k < WAYS; k++) begin
         if (!pos_found && (row_cur.order[k] == way)) begin
            pos_found = 1'b1;
            pos       = WAY_BITS'(k);
         end
      end
      for (int k = 1; k < WAYS; k++) begin
         if (WAY_BITS'(k) <= pos) begin
            row_in.order[k] = row_cur.order[k-1];
         end
      end
      row_in.order[0] = way;
   end

   always_comb begin
      access_in     = access_ff + 32'd1;
      load_in       = load_ff + 32'(item_ff.is_load);
      store_in      = store_ff + 32'(item_ff.is_store);
      hits_in       = hits_ff + 32'(hit);
      load_hits_in  = load_hits_ff + 32'(hit && item_ff.is_load);
      store_hits_in = store_hits_ff + 32'(hit && item_ff.is_store);

      rsp_data_in.hit             = hit;
      rsp_data_in.way_used        = 2'(way);
      rsp_data_in.forward_miss    = !hit;
      rsp_data_in.access_total    = access_in;
      rsp_data_in.load_total      = load_in;
      rsp_data_in.store_total     = store_in;
      rsp_data_in.hit_total       = hits_in;
      rsp_data_in.load_hit_total  = load_hits_in;
      rsp_data_in.store_hit_total = store_hits_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_FETCH: begin
            if (pop) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (do_write) begin
               state_in     = ST_FETCH;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FETCH;
         rsp_valid_ff  <= 1'b0;
         row_valid_ff  <= '0;
         access_ff     <= '0;
         load_ff       <= '0;
         store_ff      <= '0;
         hits_ff       <= '0;
         load_hits_ff  <= '0;
         store_hits_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_write) begin
            row_valid_ff[item_ff.set] <= 1'b1;
            access_ff                 <= access_in;
            load_ff                   <= load_in;
            store_ff                  <= store_in;
            hits_ff                   <= hits_in;
            load_hits_ff              <= load_hits_in;
            store_hits_ff             <= store_hits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff     <= head_item;
         rd_row_ff   <= row_mem_ff[head_item.set];
         rd_known_ff <= row_valid_ff[head_item.set];
      end
      if (do_write) begin
         row_mem_ff[item_ff.set] <= row_in;
         rsp_data_ff             <= rsp_data_in;
      end
   end

   `SALC_ASSERT_NOW(a_pop_only_in_fetch, pop, state_ff == ST_FETCH)
   `SALC_ASSERT_NEXT(a_row_marked_written, do_write, row_valid_ff[item_ff.set])
   `SALC_ASSERT_NEXT(a_access_steps_once, do_write, access_ff == $past(access_ff) + 32'd1)

endmodule
